// ===== rtl/core/lpf_pkg.sv =====
package lpf_pkg;

    localparam int ROWS_KEPT = 8;
    localparam int SLOT_W    = 3;
    localparam int WIN       = 7;
    localparam int ROW_W     = 17;
    localparam int PIX_W     = 8;

    typedef logic [SLOT_W-1:0] slot_t;

    // One column fetch of the output sequencer, as it enters the window stage.
    typedef struct packed {
        logic                 valid;
        logic                 is_out;
        logic                 rowstart;
        logic                 dup;
        logic                 wr_pre0;
        logic                 wr_pre1;
        logic                 x_odd;
        logic                 y_odd;
        logic                 last;
        slot_t [WIN-1:0]      slots;
    } step_ctl_t;

    // Control that travels with the 7x7 window into the filter.
    typedef struct packed {
        logic valid;
        logic x_odd;
        logic y_odd;
        logic last;
    } tap_ctl_t;

endpackage

// ===== rtl/core/lpf_line_mem.sv =====
module lpf_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int LW    = 24
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic [lpf_pkg::SLOT_W-1:0]            wlane,
    input  logic [LW-1:0]                         wdata,
    input  logic                                  re,
    input  logic [AW-1:0]                         raddr,
    output logic [lpf_pkg::ROWS_KEPT*LW-1:0]      rdata
);

    // One word per column, one lane per kept row.
    logic [lpf_pkg::ROWS_KEPT*LW-1:0] mem [DEPTH];
    logic [lpf_pkg::ROWS_KEPT*LW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr][wlane*LW +: LW] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lpf_step_gen.sv =====
module lpf_step_gen #(
    parameter int WW = 12,
    parameter int AW = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 grant,
    input  logic                 en,
    input  logic [WW-1:0]        eff_w,
    input  logic [15:0]          eff_h,
    output logic [1:0]           pending,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_col,
    output lpf_pkg::step_ctl_t   b_ctl
);

    logic [1:0]                   pending_reg, pending_next;
    logic                         pre_reg, pre_next;
    logic                         pidx_reg, pidx_next;
    logic [WW-1:0]                x_reg, x_next;
    logic [15:0]                  y_reg, y_next;
    lpf_pkg::step_ctl_t           b_ctl_reg, ctl;
    logic                         issue;
    logic                         tail;
    logic [WW-1:0]                col, wm1, wm2;
    logic [15:0]                  hm1;
    logic [lpf_pkg::ROW_W-1:0]    ty;
    logic signed [lpf_pkg::ROW_W:0] r, hlim;

    assign issue = en && (pending_reg != 2'd0);
    assign wm1   = eff_w - WW'(1);
    assign wm2   = eff_w - WW'(2);
    assign hm1   = eff_h - 16'd1;
    assign tail  = ({1'b0, x_reg} + (WW+1)'(3)) > {1'b0, eff_w};

    always_comb begin
        ctl   = '0;
        col   = '0;
        ty    = '0;
        r     = '0;
        hlim  = signed'({2'b00, hm1});
        if (pre_reg) begin
            col         = pidx_reg ? WW'(1) : WW'(0);
            ctl.wr_pre0 = !pidx_reg;
            ctl.wr_pre1 = pidx_reg;
        end else begin
            ctl.is_out   = 1'b1;
            ctl.rowstart = (x_reg == '0);
            ctl.x_odd    = x_reg[0];
            ctl.y_odd    = y_reg[0];
            ctl.last     = (x_reg == wm1) && (y_reg == hm1);
            if (!tail) begin
                col = x_reg + WW'(2);
                ty  = {1'b0, y_reg};
            end else begin
                // Last two columns repeat the edge; fetch the next row's first columns.
                ctl.dup     = 1'b1;
                ctl.wr_pre0 = (x_reg == wm2);
                ctl.wr_pre1 = (x_reg != wm2);
                col         = (x_reg == wm2) ? WW'(0) : WW'(1);
                ty          = {1'b0, y_reg} + lpf_pkg::ROW_W'(1);
            end
        end
        ctl.valid = issue;
        for (int i = 0; i < lpf_pkg::WIN; i++) begin
            r = signed'({1'b0, ty}) - (lpf_pkg::ROW_W+1)'(4) + (lpf_pkg::ROW_W+1)'(i);
            if (r < 0) begin
                r = '0;
            end else if (r > hlim) begin
                r = hlim;
            end
            ctl.slots[i] = r[lpf_pkg::SLOT_W-1:0];
        end
    end

    always_comb begin
        pre_next     = pre_reg;
        pidx_next    = pidx_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        pending_next = pending_reg + {1'b0, grant} - {1'b0, issue};
        if (issue) begin
            if (pre_reg) begin
                if (pidx_reg) begin
                    pre_next = 1'b0;
                    x_next   = '0;
                    y_next   = '0;
                end
                pidx_next = 1'b1;
            end else if (ctl.last) begin
                pre_next  = 1'b1;
                pidx_next = 1'b0;
            end else if (x_reg == wm1) begin
                x_next = '0;
                y_next = y_reg + 16'd1;
            end else begin
                x_next = x_reg + WW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pending_reg     <= '0;
            pre_reg         <= 1'b1;
            pidx_reg        <= 1'b0;
            x_reg           <= '0;
            y_reg           <= '0;
            b_ctl_reg.valid <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            pre_reg     <= pre_next;
            pidx_reg    <= pidx_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            if (en) begin
                b_ctl_reg <= ctl;
            end
        end
    end

    assign pending = pending_reg;
    assign rd_en   = issue;
    assign rd_col  = col[AW-1:0];
    assign b_ctl   = b_ctl_reg;

endmodule

// ===== rtl/core/lpf_window.sv =====
module lpf_window #(
    parameter int LW = 24
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              en,
    input  logic [lpf_pkg::ROWS_KEPT*LW-1:0]                  rd_data,
    input  lpf_pkg::step_ctl_t                                b_ctl,
    output logic [lpf_pkg::WIN-1:0][lpf_pkg::WIN-1:0][LW-1:0] win,
    output lpf_pkg::tap_ctl_t                                 c_ctl
);

    // win[i][j]: column x-4+i, row y-4+j
    logic [lpf_pkg::WIN-1:0][lpf_pkg::WIN-1:0][LW-1:0] win_reg, win_next;
    logic [lpf_pkg::WIN-1:0][LW-1:0]                   colv, pre0_reg, pre1_reg;
    lpf_pkg::tap_ctl_t                                 c_ctl_reg;

    always_comb begin
        for (int j = 0; j < lpf_pkg::WIN; j++) begin
            colv[j] = rd_data[b_ctl.slots[j]*LW +: LW];
        end
        if (b_ctl.rowstart) begin
            for (int i = 0; i < lpf_pkg::WIN-2; i++) begin
                win_next[i] = pre0_reg;
            end
            win_next[lpf_pkg::WIN-2] = pre1_reg;
            win_next[lpf_pkg::WIN-1] = colv;
        end else begin
            for (int i = 0; i < lpf_pkg::WIN-1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[lpf_pkg::WIN-1] = b_ctl.dup ? win_reg[lpf_pkg::WIN-1] : colv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && b_ctl.valid) begin
            if (b_ctl.wr_pre0) begin
                pre0_reg <= colv;
            end
            if (b_ctl.wr_pre1) begin
                pre1_reg <= colv;
            end
            if (b_ctl.is_out) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            c_ctl_reg.valid <= b_ctl.valid && b_ctl.is_out;
            c_ctl_reg.x_odd <= b_ctl.x_odd;
            c_ctl_reg.y_odd <= b_ctl.y_odd;
            c_ctl_reg.last  <= b_ctl.last;
        end
    end

    assign win   = win_reg;
    assign c_ctl = c_ctl_reg;

endmodule

// ===== rtl/core/lpf_filter.sv =====
module lpf_filter #(
    parameter int USED = 3
) (
    input  logic                                                     aclk,
    input  logic                                                     aresetn,
    input  logic                                                     en,
    input  logic [lpf_pkg::WIN-1:0][lpf_pkg::WIN-1:0][USED*8-1:0]    win,
    input  lpf_pkg::tap_ctl_t                                        c_ctl,
    output logic                                                     m_tvalid,
    output logic [23:0]                                              m_tdata,
    output logic                                                     m_tlast
);

    localparam int TAPS = 6;

    // Combined reduce-then-expand weights, 32 in total per axis.
    function automatic logic [3:0] kern(input int k);
        logic [3:0] v;
        case (k)
            0:       v = 4'd1;
            1:       v = 4'd3;
            2:       v = 4'd6;
            3:       v = 4'd10;
            4:       v = 4'd9;
            5:       v = 4'd3;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    logic [12:0]       vs        [USED][lpf_pkg::WIN];
    logic [12:0]       vsel_next [USED][TAPS];
    logic [12:0]       vsel_reg  [USED][TAPS];
    logic [7:0]        ctr_reg   [USED];
    logic [7:0]        res_next  [USED];
    logic [7:0]        res_reg   [USED];
    logic              d_valid_reg, d_last_reg;
    logic              out_valid_reg, out_last_reg;
    logic [12:0]       acc;
    logic [17:0]       up, p;
    int                ro, co;

    // Vertical pass: six rows starting at the parity-selected offset.
    always_comb begin
        ro = c_ctl.y_odd ? 0 : 1;
        co = c_ctl.x_odd ? 0 : 1;
        acc = '0;
        for (int ch = 0; ch < USED; ch++) begin
            for (int i = 0; i < lpf_pkg::WIN; i++) begin
                acc = '0;
                for (int b = 0; b < TAPS; b++) begin
                    acc = acc + 13'(kern(b)) * 13'(win[i][ro+b][ch*8 +: 8]);
                end
                vs[ch][i] = acc;
            end
            for (int a = 0; a < TAPS; a++) begin
                vsel_next[ch][a] = vs[ch][co+a];
            end
        end
    end

    // Horizontal pass and difference against the center pixel.
    always_comb begin
        up = '0;
        p  = '0;
        for (int ch = 0; ch < USED; ch++) begin
            up = '0;
            for (int a = 0; a < TAPS; a++) begin
                up = up + 18'(kern(a)) * 18'(vsel_reg[ch][a]);
            end
            p = {ctr_reg[ch], 10'd0};
            res_next[ch] = (p > up) ? 8'((p - up) >> 10) : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vsel_reg <= vsel_next;
            for (int ch = 0; ch < USED; ch++) begin
                ctr_reg[ch] <= win[4][4][ch*8 +: 8];
            end
            d_last_reg   <= c_ctl.last;
            res_reg      <= res_next;
            out_last_reg <= d_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg   <= c_ctl.valid;
            out_valid_reg <= d_valid_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_out
        if (c < USED) begin : g_used
            assign m_tdata[c*8 +: 8] = res_reg[c];
        end else begin : g_zero
            assign m_tdata[c*8 +: 8] = 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/laplacian_pyramid_first_level.sv =====
// First level of a Laplacian pyramid over a stream of 3-channel 8-bit pixels.
// Input transactions (s_*) carry pixels in raster order, s_tuser = 0, or drain
// ticks, s_tuser = 1. Output transactions (m_*) carry the detail value of
// each pixel, clamped to 0..255, with m_tlast on the frame's final pixel.
// Output (x,y) becomes due after input (x+2,y+2), a lag of 2*W+2
// transactions; after the last pixel of a frame send 2*W+2 drain ticks to
// flush it. Drain ticks sent while a frame is still arriving are dropped.
// Throughput: one transaction per cycle on both sides while neither side
// stalls. A due output passes through the step backlog, line memory read,
// window shift, vertical taps, then horizontal taps plus subtract.
// The line memory holds 8 rows of up to MAX_WIDTH columns, one row per lane
// of a column word; at most one column is written and one read each cycle.
// Reset (aresetn low, synchronous) clears all counters and sets W=640,
// H=480; the line memory is not cleared. A cfg write (W, H) also restarts
// the frame; write config only while the block is idle.
// When m_tvalid is high and m_tready low the pipeline holds; s_tready
// drops once two granted steps are waiting to be started.
module laplacian_pyramid_first_level #(
    parameter int MAX_WIDTH = 2048,
    parameter int CHANNELS  = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sample_ch0, sample_ch1, sample_ch2
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // detail_ch0, detail_ch1, detail_ch2
    output logic        m_tlast,   // frame_last
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int USED = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int LW   = USED * 8;
    localparam int RW   = lpf_pkg::ROW_W;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic       REQ_PIXEL        = 1'b0;
    localparam logic       REQ_DRAIN        = 1'b1;

    logic [11:0]   frame_width_reg;
    logic [15:0]   frame_height_reg;
    logic [WW-1:0] eff_w;
    logic [15:0]   eff_h;

    logic [WW-1:0] in_col_reg, in_col_next, col_adv, col_inc;
    logic [RW-1:0] in_row_reg, in_row_next, row_adv;

    logic          accept, active, advance, wr_pix, grant, frame_done, en;
    logic [1:0]    pending;
    logic          rd_en;
    logic [AW-1:0] rd_col;
    logic [lpf_pkg::ROWS_KEPT*LW-1:0]                   rd_data;
    lpf_pkg::step_ctl_t                                 b_ctl;
    lpf_pkg::tap_ctl_t                                  c_ctl;
    logic [lpf_pkg::WIN-1:0][lpf_pkg::WIN-1:0][LW-1:0]  win;

    // Saturate the configured geometry into the supported range.
    always_comb begin
        if (frame_width_reg < 12'd4) begin
            eff_w = WW'(4);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width_reg);
        end
        eff_h = (frame_height_reg < 16'd4) ? 16'd4 : frame_height_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 16'd480;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[11:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input side: hold the frame position, write pixels, grant output steps.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = (pending < 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign active   = in_row_reg < RW'(eff_h);
    // Drop drain ticks while the frame is still arriving; late pixels drain.
    assign advance  = accept && !(active && (s_tuser == REQ_DRAIN));
    assign wr_pix   = accept && active && (s_tuser == REQ_PIXEL);

    always_comb begin
        col_inc = in_col_reg + WW'(1);
        if (col_inc >= eff_w) begin
            col_adv = '0;
            row_adv = in_row_reg + RW'(1);
        end else begin
            col_adv = col_inc;
            row_adv = in_row_reg;
        end
    end

    // Each transaction past position (0,2) starts one step: two prefetch
    // steps per frame, then one per output pixel.
    assign grant = advance &&
                   ((row_adv > RW'(2)) || ((row_adv == RW'(2)) && (col_adv != '0)));
    assign frame_done = advance && (row_adv == (RW'(eff_h) + RW'(2))) &&
                        (col_adv == WW'(2));

    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (cfg_we || frame_done) begin
            in_col_next = '0;
            in_row_next = '0;
        end else if (advance) begin
            in_col_next = col_adv;
            in_row_next = row_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    lpf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .LW    (LW)
    ) u_mem (
        .aclk  (aclk),
        .we    (wr_pix),
        .waddr (in_col_reg[AW-1:0]),
        .wlane (in_row_reg[lpf_pkg::SLOT_W-1:0]),
        .wdata (s_tdata[LW-1:0]),
        .re    (rd_en),
        .raddr (rd_col),
        .rdata (rd_data)
    );

    lpf_step_gen #(
        .WW (WW),
        .AW (AW)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_we),
        .grant   (grant),
        .en      (en),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .pending (pending),
        .rd_en   (rd_en),
        .rd_col  (rd_col),
        .b_ctl   (b_ctl)
    );

    lpf_window #(
        .LW (LW)
    ) u_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rd_data (rd_data),
        .b_ctl   (b_ctl),
        .win     (win),
        .c_ctl   (c_ctl)
    );

    lpf_filter #(
        .USED (USED)
    ) u_filt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .win      (win),
        .c_ctl    (c_ctl),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Input is throttled so that at most two steps ever wait.
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending != 2'd3)
        else $error("step backlog overflow");

    // The row counter stops at two rows past the frame while draining.
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_row_reg <= (RW'(eff_h) + RW'(2)))
        else $error("input row ran past the drain window");

    // A frame-completing transaction always starts the frame's final step.
    a_done_grants: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |-> grant)
        else $error("frame ended without its last step");

endmodule

// ===== sim/tb.sv =====
module tb;

    // One expected detail pixel as it should leave the master side.
    typedef struct {
        logic [23:0] detail;   // detail_ch0, detail_ch1, detail_ch2
        logic        last;
    } detail_item_t;

    // Tracks the frame as the block sees it and predicts every detail pixel.
    class detail_scoreboard;
        logic [7:0]   line_rows[8][2048][3];
        int unsigned  width_reg;
        int unsigned  height_reg;
        int unsigned  in_col;
        int unsigned  in_row;
        int unsigned  out_col;
        int unsigned  out_row;
        detail_item_t pending[$];
        int           mismatches;

        function void clear_position();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void reset_state();
            width_reg = 640;
            height_reg = 480;
            clear_position();
        endfunction

        // Any register write restarts the frame.
        function void write_reg(bit idx, logic [15:0] value);
            if (idx == 1'b0) width_reg = value[11:0];
            else height_reg = value;
            clear_position();
        endfunction

        function int unsigned active_w();
            if (width_reg < 4) return 4;
            if (width_reg > 2048) return 2048;
            return width_reg;
        endfunction

        function int unsigned active_h();
            return (height_reg < 4) ? 4 : height_reg;
        endfunction

        // Edge-clamped fetch from the line store.
        function int unsigned sample_at(int x, int y, int c, int w, int h);
            if (x < 0) x = 0;
            if (x > w - 1) x = w - 1;
            if (y < 0) y = 0;
            if (y > h - 1) y = h - 1;
            return line_rows[y % 8][x][c];
        endfunction

        // Half-resolution value in sixty-fourths, 1-3-3-1 in both directions.
        function int unsigned coarse_sum(int cx, int cy, int c, int w, int h);
            int unsigned acc;
            int unsigned ta;
            int unsigned tb_;
            acc = 0;
            for (int b = 0; b < 4; b++) begin
                tb_ = (b == 0 || b == 3) ? 1 : 3;
                for (int a = 0; a < 4; a++) begin
                    ta = (a == 0 || a == 3) ? 1 : 3;
                    acc += ta * tb_ * sample_at(2 * cx - 1 + a, 2 * cy - 1 + b, c, w, h);
                end
            end
            return acc;
        endfunction

        function void note_input(logic req, logic [23:0] data);
            int unsigned  w;
            int unsigned  h;
            int unsigned  due;
            int           cx;
            int           cy;
            int unsigned  up;
            int unsigned  orig;
            int unsigned  v;
            detail_item_t item;
            w = active_w();
            h = active_h();
            if (in_row < h) begin
                if (req) return;
                for (int c = 0; c < 3; c++)
                    line_rows[in_row % 8][in_col][c] = data[8*c +: 8];
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            due = in_row * w + in_col;
            if (due <= 2 * w + 2) return;
            cx = out_col / 2;
            cy = out_row / 2;
            for (int c = 0; c < 3; c++) begin
                up = coarse_sum(cx - 1, cy - 1, c, w, h)
                   + 3 * coarse_sum(cx, cy - 1, c, w, h)
                   + 3 * coarse_sum(cx - 1, cy, c, w, h)
                   + 9 * coarse_sum(cx, cy, c, w, h);
                orig = sample_at(out_col, out_row, c, w, h) * 1024;
                v = 0;
                if (orig > up) begin
                    v = (orig - up) / 1024;
                    if (v > 255) v = 255;
                end
                item.detail[8*c +: 8] = v[7:0];
            end
            item.last = 1'b0;
            if (out_row == h - 1 && out_col == w - 1) begin
                item.last = 1'b1;
                clear_position();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
            pending.push_back(item);
        endfunction

        function void check_result(logic [23:0] detail, logic last);
            detail_item_t exp_item;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected detail %h last %b", detail, last);
                return;
            end
            exp_item = pending.pop_front();
            if (detail !== exp_item.detail || last !== exp_item.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("detail mismatch: expected %h last %b, got %h last %b",
                             exp_item.detail, exp_item.last, detail, last);
            end
        endfunction
    endclass

    localparam bit REG_WIDTH  = 1'b0;
    localparam bit REG_HEIGHT = 1'b1;
    localparam bit REQ_PIXEL  = 1'b0;
    localparam bit REQ_DRAIN  = 1'b1;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    detail_scoreboard sb;
    bit               gaps_on;
    int               stim_count;

    laplacian_pyramid_first_level u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block wedges.
    initial begin
        #(12 * 1500000);
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: check every completed transaction, then pick the next ready.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            m_tready <= gaps_on ? ($urandom_range(99) >= 13) : 1'b1;
        end
    end

    // Offer one input transaction and hold it until the block takes it.
    task automatic send_item(logic req, logic [23:0] data);
        while (gaps_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(req, data);
    endtask

    // Drop valid and wait until the pipeline has nothing left in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(bit idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    function automatic logic [23:0] pick_pixel(bit extremes);
        logic [23:0] d;
        d = 24'($urandom);
        if (extremes)
            for (int c = 0; c < 3; c++) d[8*c +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
        return d;
    endfunction

    // Stream one frame: pixels with stray drain ticks, then the flush.
    // A nonzero stop_at abandons the frame after that many pixels.
    task automatic run_frame(int w, int h, bit extremes, int stop_at, int hold_at);
        int total;
        total = w * h;
        settle();
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        for (int i = 0; i < total; i++) begin
            if (stop_at != 0 && i == stop_at) return;
            if (i == hold_at) begin
                // Let every due output leave before the next pixel.
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.pending.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(99) < 3) send_item(REQ_DRAIN, 24'($urandom));
            send_item(REQ_PIXEL, pick_pixel(extremes));
            stim_count++;
        end
        // Flush with drain ticks and the odd pixel, which also flushes.
        for (int i = 0; i < 2 * w + 2; i++) begin
            send_item($urandom_range(99) < 70 ? REQ_DRAIN : REQ_PIXEL, 24'($urandom));
            stim_count++;
        end
    endtask

    initial begin
        int w;
        int h;
        sb = new();
        gaps_on    = 1'b1;
        stim_count = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        sb.reset_state();
        @(posedge aclk);

        // Drain ticks to an idle block are dropped.
        send_item(REQ_DRAIN, 24'hffffff);
        send_item(REQ_DRAIN, 24'h000000);

        // Smallest frame, saturating pixel values, hold midway.
        run_frame(4, 4, 1'b1, 0, 12);
        // Zero registers saturate to 4x4.
        settle();
        write_reg(REG_WIDTH, 16'h0000);
        write_reg(REG_HEIGHT, 16'h0000);
        for (int i = 0; i < 16 + 10; i++)
            send_item(i < 16 ? REQ_PIXEL : REQ_DRAIN, pick_pixel(1'b1));
        // Largest register values: start a frame and abandon it.
        settle();
        write_reg(REG_WIDTH, 16'h0fff);
        write_reg(REG_HEIGHT, 16'hffff);
        for (int i = 0; i < 60; i++) send_item(REQ_PIXEL, 24'($urandom));
        // Full-width frame: start it and abandon it early.
        run_frame(2048, 4, 1'b0, 300, -1);
        // A wider complete frame, four rows tall.
        run_frame(64, 4, 1'b0, 0, -1);

        while (stim_count < 1950) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(4, 12);
            h = $urandom_range(4, 12);
            // Hold a long stretch with no gaps on either side.
            gaps_on = !(stim_count > 800 && stim_count < 1200);
            run_frame(w, h, $urandom_range(3) == 0,
                      ($urandom_range(9) == 0) ? $urandom_range(1, w * h - 1) : 0, -1);
        end
        gaps_on = 1'b1;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lpf_pkg.sv
rtl/core/lpf_line_mem.sv
rtl/core/lpf_step_gen.sv
rtl/core/lpf_window.sv
rtl/core/lpf_filter.sv
rtl/core/laplacian_pyramid_first_level.sv
sim/tb.sv
